FILE: hw/rtl/rcp_pkg.sv
`timescale 1ns / 1ps

package rcp_pkg;

   // Configuration register indexes.
   typedef enum logic [7:0] {
      REG_NUMERATOR   = 8'd0,
      REG_DENOMINATOR = 8'd1,
      REG_Z_ANGLE     = 8'd2
   } reg_index_type;

   localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
   localparam logic [31:0]        RadToTurnQ32  = 32'd683565276;
   localparam logic signed [15:0] Q15Max        = 16'sd32767;

   // Arctangent of 2^-i in turns, Q0.32.
   function automatic logic [31:0] atan_turns(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
         3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
         9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
         12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
         15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
         18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
         21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
         default: t = 32'h0;
      endcase
      return t;
   endfunction

   // Round half up by 15 bits and saturate to +-32767.
   function automatic logic signed [15:0] round_sat(input logic signed [35:0] v);
      logic signed [35:0] s;
      s = (v + 36'sd16384) >>> 15;
      if (s > 36'sd32767) return Q15Max;
      if (s < -36'sd32767) return -Q15Max;
      return s[15:0];
   endfunction

   // Phases handed from the front part to the CORDIC back part.
   typedef struct packed {
      logic [31:0] th_ph;
      logic [31:0] rose_ph;
      logic [31:0] z_ph;
   } phase_word_type;

   typedef struct packed {
      logic signed [15:0] x_out;
      logic signed [15:0] y_out;
      logic signed [15:0] z_out;
      logic               at_origin;
   } result_word_type;

endpackage

FILE: hw/rtl/rcp_if.sv
`timescale 1ns / 1ps

interface rcp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] position;
   modport source (output valid, output position, input ready);
   modport sink (input valid, input position, output ready);
endinterface

interface rcp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_out;
   logic signed [15:0] y_out;
   logic signed [15:0] z_out;
   logic               at_origin;
   modport source (output valid, output x_out, output y_out, output z_out,
                   output at_origin, input ready);
   modport sink (input valid, input x_out, input y_out, input z_out,
                 input at_origin, output ready);
endinterface

interface rcp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/rcp_front.sv
`timescale 1ns / 1ps

// Front part: turns a position into the three CORDIC phases over two stages.
module rcp_front #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [15:0]                  position,
   input  logic [7:0]                   numerator,
   input  logic [7:0]                   denominator,
   input  logic signed [7:0]            z_angle,
   output logic                         out_valid,
   input  logic                         out_ready,
   output rcp_pkg::phase_word_type      out_word
);
   logic        s1_valid_ff, s1_valid_in;
   logic [24:0] th_prod_ff, rose_prod_ff;
   logic [31:0] zmul_ff;
   logic        s2_valid_ff, s2_valid_in;
   rcp_pkg::phase_word_type s2_word_ff, s2_word_in;
   logic [7:0]  d_eff;
   logic        both_odd;
   logic        adv1, adv2;
   logic [39:0] z_full;
   logic [31:0] th_wide, rose_wide;

   // Stall control of the two front stages.
   assign adv2     = !s2_valid_ff || out_ready;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   // Stage one: products of position and the petal counts, and of z_angle and the turn scale.
   always_comb begin
      d_eff       = (denominator == 8'd0) ? 8'd1 : denominator;
      both_odd    = numerator[0] && d_eff[0];
      z_full      = 40'($signed(z_angle)) * 40'(rcp_pkg::RadToTurnQ32);
      s1_valid_in = adv1 ? in_valid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (adv1 && in_valid) begin
         th_prod_ff   <= 25'(({17'd0, position} * 25'(d_eff)) << both_odd);
         rose_prod_ff <= 25'(({17'd0, position} * 25'(numerator)) << both_odd);
         zmul_ff      <= z_full[31:0];
      end
   end

   // Stage two: keep the top ANGLE_BITS fraction bits of each phase.
   // The products are padded below so that resolutions finer than 17 bits fit.
   always_comb begin
      th_wide            = {th_prod_ff, 7'd0};
      rose_wide          = {rose_prod_ff, 7'd0};
      s2_word_in.th_ph   = {th_wide[23:24-ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
      s2_word_in.rose_ph = {rose_wide[23:24-ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
      s2_word_in.z_ph    = {zmul_ff[31:32-ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
      s2_valid_in        = adv2 ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (adv2 && s1_valid_ff) begin
         s2_word_ff <= s2_word_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_word  = s2_word_ff;
endmodule

FILE: hw/rtl/rcp_queue.sv
`timescale 1ns / 1ps

// Two-entry queue between the front and the back part.
module rcp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rcp_pkg::phase_word_type in_word,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rcp_pkg::phase_word_type out_word
);
   rcp_pkg::phase_word_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_word  = mem_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_word;
      end
   end
endmodule

FILE: hw/rtl/rcp_back.sv
`timescale 1ns / 1ps

// Back part: three pipelined CORDICs, then the products and rounding.
module rcp_back #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rcp_pkg::phase_word_type  in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rcp_pkg::result_word_type out_word
);
   // Load stage, the rotations, rounding, products and the result register.
   localparam int Depth = CORDIC_STAGES + 4;

   logic                    adv;
   logic [Depth-1:0]        vld_ff, vld_in;
   // Per-unit rotation state: unit 0 theta, 1 rose, 2 z.
   logic signed [33:0]      cx_ff [3][CORDIC_STAGES+1];
   logic signed [33:0]      cy_ff [3][CORDIC_STAGES+1];
   logic signed [32:0]      cz_ff [3][CORDIC_STAGES+1];
   logic                    flip_ff [3][CORDIC_STAGES+1];
   logic signed [15:0]      cth_ff, sth_ff, sro_ff, sz_ff;
   logic signed [31:0]      px_ff, py_ff, pz_ff;
   rcp_pkg::result_word_type res_ff;
   logic [31:0]             ph [3];

   // The whole pipe moves together; it stalls while the result waits.
   assign adv      = !vld_ff[Depth-1] || out_ready;
   assign in_ready = adv;
   assign vld_in   = {vld_ff[Depth-2:0], in_valid};
   assign ph[0]    = in_word.th_ph;
   assign ph[1]    = in_word.rose_ph;
   assign ph[2]    = in_word.z_ph;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Quadrant fold and one rotation per stage.
   for (genvar u = 0; u < 3; u++) begin : g_unit
      logic        flip;
      logic [31:0] pf;
      assign flip = ph[u][31] ^ ph[u][30];
      assign pf   = flip ? ph[u] - 32'h80000000 : ph[u];
      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[u][0]   <= rcp_pkg::CordicGainQ30;
            cy_ff[u][0]   <= '0;
            cz_ff[u][0]   <= 33'($signed(pf));
            flip_ff[u][0] <= flip;
         end
      end
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
         logic signed [33:0] dx, dy;
         assign dx = cy_ff[u][i] >>> i;
         assign dy = cx_ff[u][i] >>> i;
         always_ff @(posedge clock) begin
            if (adv) begin
               flip_ff[u][i+1] <= flip_ff[u][i];
               if (!cz_ff[u][i][32]) begin
                  cx_ff[u][i+1] <= cx_ff[u][i] - dx;
                  cy_ff[u][i+1] <= cy_ff[u][i] + dy;
                  cz_ff[u][i+1] <= cz_ff[u][i] - 33'(rcp_pkg::atan_turns(i));
               end else begin
                  cx_ff[u][i+1] <= cx_ff[u][i] + dx;
                  cy_ff[u][i+1] <= cy_ff[u][i] - dy;
                  cz_ff[u][i+1] <= cz_ff[u][i] + 33'(rcp_pkg::atan_turns(i));
               end
            end
         end
      end
   end

   // Rounding of the CORDIC outputs to Q1.15.
   function automatic logic signed [15:0] fin(input logic signed [33:0] v,
                                              input logic f);
      logic signed [35:0] w;
      w = f ? -36'(v) : 36'(v);
      return rcp_pkg::round_sat(w);
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         cth_ff <= fin(cx_ff[0][CORDIC_STAGES], flip_ff[0][CORDIC_STAGES]);
         sth_ff <= fin(cy_ff[0][CORDIC_STAGES], flip_ff[0][CORDIC_STAGES]);
         sro_ff <= fin(cy_ff[1][CORDIC_STAGES], flip_ff[1][CORDIC_STAGES]);
         sz_ff  <= fin(cy_ff[2][CORDIC_STAGES], flip_ff[2][CORDIC_STAGES]);
         px_ff  <= sro_ff * cth_ff;
         py_ff  <= sro_ff * sth_ff;
         pz_ff  <= sro_ff * sz_ff;
         res_ff.x_out     <= rcp_pkg::round_sat(36'(px_ff));
         res_ff.y_out     <= rcp_pkg::round_sat(36'(py_ff));
         res_ff.z_out     <= rcp_pkg::round_sat(36'(pz_ff));
         res_ff.at_origin <= (rcp_pkg::round_sat(36'(px_ff)) == 16'sd0)
                          && (rcp_pkg::round_sat(36'(py_ff)) == 16'sd0)
                          && (rcp_pkg::round_sat(36'(pz_ff)) == 16'sd0);
      end
   end

   assign out_valid = vld_ff[Depth-1];
   assign out_word  = res_ff;
endmodule

FILE: hw/rtl/rose_curve_point.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields
// req      in   position (Q0.16)
// rsp      out  x_out, y_out, z_out (Q1.15), at_origin
// csr      in   index, data (0 numerator, 1 denominator, 2 z_angle)
// One item per cycle sustained while rsp stays ready; an item passes the front, the queue and the back pipe.
// CORDIC_STAGES sets the depth of the back pipe; every stage is registered.
// Synchronous reset clears the valid flags and loads n = 1, d = 1, z_angle = 0.
// A stalled rsp holds the back pipe; the queue and front fill, then req drops ready.
module rose_curve_point #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input logic       clock,
   input logic       reset,
   rcp_req_if.sink   req,
   rcp_rsp_if.source rsp,
   rcp_csr_if.sink   csr
);
   logic [7:0]        num_ff, den_ff;
   logic signed [7:0] zang_ff;
   logic              f_valid, f_ready, b_valid, b_ready, b_out_valid;
   rcp_pkg::phase_word_type  f_word, b_word;
   rcp_pkg::result_word_type r_word;

   // Configuration registers.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff  <= 8'd1;
         den_ff  <= 8'd1;
         zang_ff <= 8'sd0;
      end else if (csr.valid) begin
         case (csr.index)
            rcp_pkg::REG_NUMERATOR:   num_ff  <= csr.data;
            rcp_pkg::REG_DENOMINATOR: den_ff  <= csr.data;
            rcp_pkg::REG_Z_ANGLE:     zang_ff <= $signed(csr.data);
            default: ;
         endcase
      end
   end

   rcp_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .position(req.position),
      .numerator(num_ff), .denominator(den_ff), .z_angle(zang_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_word(f_word));

   rcp_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
      .out_valid(b_valid), .out_ready(b_ready), .out_word(b_word));

   rcp_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(b_valid), .in_ready(b_ready), .in_word(b_word),
      .out_valid(b_out_valid), .out_ready(rsp.ready), .out_word(r_word));

   assign rsp.valid     = b_out_valid;
   assign rsp.x_out     = r_word.x_out;
   assign rsp.y_out     = r_word.y_out;
   assign rsp.z_out     = r_word.z_out;
   assign rsp.at_origin = r_word.at_origin;

   // The x and y outputs stay within the saturation bounds.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.x_out != 16'sh8000 && rsp.y_out != 16'sh8000))
      else $error("x or y output outside saturation range");
   // The origin flag agrees with the coordinates.
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.at_origin == (rsp.x_out == 16'sd0 && rsp.y_out == 16'sd0
                                       && rsp.z_out == 16'sd0)))
      else $error("origin flag mismatch");
   // A waiting result word stays valid and unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.x_out)
         && $stable(rsp.y_out) && $stable(rsp.z_out) && $stable(rsp.at_origin)))
      else $error("result word changed while stalled");
endmodule
